@@ sv/abump_pkg.sv @@
package abump_pkg;

  localparam int ARENA_MAX_BYTES = 1048576;

  localparam int FUNC_W      = 3;
  localparam int OFF_W       = 21;
  localparam int ADDR_W      = 32;
  localparam int ALIGN_LOG_W = 4;
  // Widest alignment a four-bit exponent can ask for is 2^15 bytes.
  localparam int ALIGN_W     = 15;
  localparam int STATUS_W    = 2;
  localparam int KIND_W      = 3;

  localparam logic [OFF_W-1:0] ARENA_MAX = OFF_W'(ARENA_MAX_BYTES);

  localparam logic [FUNC_W-1:0] FN_ALLOC     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ALLOC_NZ  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_FREE      = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FREE_ALL  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RESIZE    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_RESIZE_NZ = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SNAPSHOT  = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RESTORE   = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_MEM  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_OLD = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd3;

  // Request classes produced by the front end.
  localparam logic [KIND_W-1:0] K_BUMP    = 3'd0;
  localparam logic [KIND_W-1:0] K_FREE    = 3'd1;
  localparam logic [KIND_W-1:0] K_CLEAR   = 3'd2;
  localparam logic [KIND_W-1:0] K_SNAP    = 3'd3;
  localparam logic [KIND_W-1:0] K_LOAD    = 3'd4;
  localparam logic [KIND_W-1:0] K_RESIZE  = 3'd5;
  localparam logic [KIND_W-1:0] K_BAD_OLD = 3'd6;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               zeroed;
    logic [OFF_W-1:0]   size;
    logic [ALIGN_W-1:0] align_mask;
    logic [OFF_W-1:0]   old_off;
    logic [OFF_W-1:0]   old_len;
    logic               old_aligned;
    logic [OFF_W-1:0]   snap_cur;
    logic [OFF_W-1:0]   snap_prev;
  } abump_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
    logic [OFF_W-1:0]    copy_len;
    logic [OFF_W-1:0]    clr_off;
    logic [OFF_W-1:0]    clr_len;
    logic [OFF_W-1:0]    cur_off;
    logic [OFF_W-1:0]    prev_off;
  } abump_rsp_t;

  typedef struct packed {
    logic empty;
    logic full;
  } abump_qstat_t;

  function automatic logic [OFF_W-1:0] usable_len(input logic [OFF_W-1:0] arena_len);
    return (arena_len < ARENA_MAX) ? arena_len : ARENA_MAX;
  endfunction

endpackage

@@ sv/abump_front.sv @@
module abump_front (
  input  logic [abump_pkg::ADDR_W-1:0]      base_address,
  input  logic [abump_pkg::OFF_W-1:0]       usable,
  input  abump_pkg::abump_qstat_t           qstat,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [abump_pkg::FUNC_W-1:0]      in_func,
  input  logic [abump_pkg::OFF_W-1:0]       in_request_size,
  input  logic [abump_pkg::ALIGN_LOG_W-1:0] in_align_log2,
  input  logic [abump_pkg::ADDR_W-1:0]      in_old_address,
  input  logic [abump_pkg::OFF_W-1:0]       in_old_length,
  input  logic [abump_pkg::OFF_W-1:0]       in_snap_current,
  input  logic [abump_pkg::OFF_W-1:0]       in_snap_previous,
  output logic                              push,
  output abump_pkg::abump_req_t             req
);

  logic [abump_pkg::ALIGN_W:0]   align_one;
  logic [abump_pkg::ALIGN_W-1:0] align_mask;
  logic [abump_pkg::ADDR_W:0]    limit;
  logic [abump_pkg::ADDR_W-1:0]  old_diff;
  logic                          old_below;
  logic                          old_above;
  logic                          no_old;

  assign in_ready = !qstat.full;
  assign push     = in_valid && in_ready;

  assign align_one  = (abump_pkg::ALIGN_W+1)'(1) << in_align_log2;
  assign align_mask = abump_pkg::ALIGN_W'(align_one - (abump_pkg::ALIGN_W+1)'(1));

  assign limit     = {1'b0, base_address} + (abump_pkg::ADDR_W+1)'(usable);
  assign old_below = in_old_address < base_address;
  assign old_above = {1'b0, in_old_address} >= limit;
  // Inside the arena the difference is below the arena length, so 21 bits hold it.
  assign old_diff  = in_old_address - base_address;
  assign no_old    = (in_old_address == '0) || (in_old_length == '0);

  always_comb begin
    req             = '0;
    req.zeroed      = (in_func == abump_pkg::FN_ALLOC) || (in_func == abump_pkg::FN_RESIZE);
    req.size        = in_request_size;
    req.align_mask  = align_mask;
    req.old_off     = old_diff[abump_pkg::OFF_W-1:0];
    req.old_len     = in_old_length;
    req.old_aligned = (in_old_address[abump_pkg::ALIGN_W-1:0] & align_mask) == '0;
    req.snap_cur    = in_snap_current;
    req.snap_prev   = in_snap_previous;
    unique case (in_func)
      abump_pkg::FN_ALLOC,
      abump_pkg::FN_ALLOC_NZ:  req.kind = abump_pkg::K_BUMP;
      abump_pkg::FN_FREE:      req.kind = abump_pkg::K_FREE;
      abump_pkg::FN_FREE_ALL:  req.kind = abump_pkg::K_CLEAR;
      abump_pkg::FN_RESIZE,
      abump_pkg::FN_RESIZE_NZ: begin
        if (no_old) begin
          req.kind = abump_pkg::K_BUMP;
        end else if (old_below || old_above) begin
          req.kind = abump_pkg::K_BAD_OLD;
        end else begin
          req.kind = abump_pkg::K_RESIZE;
        end
      end
      abump_pkg::FN_SNAPSHOT:  req.kind = abump_pkg::K_SNAP;
      abump_pkg::FN_RESTORE:   req.kind = abump_pkg::K_LOAD;
      default:                 req.kind = abump_pkg::K_SNAP;
    endcase
  end

endmodule

@@ sv/abump_queue.sv @@
module abump_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  abump_pkg::abump_req_t push_data,
  input  logic                  pop,
  output abump_pkg::abump_req_t pop_data,
  output abump_pkg::abump_qstat_t qstat
);

  abump_pkg::abump_req_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign qstat.empty = (count_r == 2'd0);
  assign qstat.full  = (count_r == 2'd2);
  assign pop_data    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ sv/abump_back.sv @@
module abump_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [abump_pkg::ADDR_W-1:0] base_address,
  input  logic [abump_pkg::OFF_W-1:0]  usable,
  input  abump_pkg::abump_qstat_t      qstat,
  input  abump_pkg::abump_req_t        req,
  output logic                         pop,
  input  logic                         out_ready,
  output logic                         out_valid,
  output abump_pkg::abump_rsp_t        rsp
);

  localparam int OW = abump_pkg::OFF_W;
  localparam int AW = abump_pkg::ALIGN_W;

  logic [OW-1:0] top_r, top_nxt;
  logic [OW-1:0] last_r, last_nxt;
  logic          out_valid_r, out_valid_nxt;
  abump_pkg::abump_rsp_t rsp_r, rsp_nxt;

  logic [AW-1:0] low_sum;
  logic [AW-1:0] pad;
  logic [OW:0]   bump_off;
  logic [OW+1:0] bump_end;
  logic          bump_fit;
  logic [abump_pkg::ADDR_W-1:0] bump_addr;
  logic          in_place;
  logic [OW:0]   ip_top;
  logic          ip_fit;
  logic          grows;

  assign pop       = !qstat.empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign rsp       = rsp_r;

  // Padding up to the alignment depends only on the low bits of base plus top.
  assign low_sum   = base_address[AW-1:0] + top_r[AW-1:0];
  assign pad       = (~low_sum + AW'(1)) & req.align_mask;
  assign bump_off  = {1'b0, top_r} + (OW+1)'(pad);
  assign bump_end  = {1'b0, bump_off} + (OW+2)'(req.size);
  assign bump_fit  = bump_end <= (OW+2)'(usable);
  assign bump_addr = base_address + abump_pkg::ADDR_W'(bump_off);

  assign in_place  = (req.old_off == last_r) && req.old_aligned;
  assign ip_top    = {1'b0, last_r} + {1'b0, req.size};
  assign ip_fit    = ip_top <= (OW+1)'(usable);
  assign grows     = req.old_len < req.size;

  always_comb begin
    rsp_nxt  = '0;
    top_nxt  = top_r;
    last_nxt = last_r;
    unique case (req.kind)
      abump_pkg::K_BUMP: begin
        if (bump_fit) begin
          rsp_nxt.addr = bump_addr;
          last_nxt     = bump_off[OW-1:0];
          top_nxt      = bump_end[OW-1:0];
          if (req.zeroed) begin
            rsp_nxt.clr_off = bump_off[OW-1:0];
            rsp_nxt.clr_len = req.size;
          end
        end else begin
          rsp_nxt.status = abump_pkg::ST_NO_MEM;
        end
      end
      abump_pkg::K_FREE:    rsp_nxt.status = abump_pkg::ST_NO_FREE;
      abump_pkg::K_CLEAR: begin
        top_nxt  = '0;
        last_nxt = '0;
      end
      abump_pkg::K_SNAP:    rsp_nxt.status = abump_pkg::ST_OK;
      abump_pkg::K_LOAD: begin
        top_nxt  = req.snap_cur;
        last_nxt = req.snap_prev;
      end
      abump_pkg::K_BAD_OLD: rsp_nxt.status = abump_pkg::ST_BAD_OLD;
      abump_pkg::K_RESIZE: begin
        if (in_place) begin
          // The most recent block grows or shrinks where it stands; the bound is
          // checked before any state moves.
          if (ip_fit) begin
            top_nxt      = ip_top[OW-1:0];
            rsp_nxt.addr = base_address + abump_pkg::ADDR_W'(last_r);
            if (grows && req.zeroed) begin
              rsp_nxt.clr_off = last_r + req.old_len;
              rsp_nxt.clr_len = req.size - req.old_len;
            end
          end else begin
            rsp_nxt.status = abump_pkg::ST_NO_MEM;
          end
        end else if (bump_fit) begin
          rsp_nxt.addr     = bump_addr;
          rsp_nxt.copy_len = grows ? req.old_len : req.size;
          last_nxt         = bump_off[OW-1:0];
          top_nxt          = bump_end[OW-1:0];
          if (req.zeroed) begin
            rsp_nxt.clr_off = bump_off[OW-1:0];
            rsp_nxt.clr_len = req.size;
          end
        end else begin
          rsp_nxt.status = abump_pkg::ST_NO_MEM;
        end
      end
      default:              rsp_nxt.status = abump_pkg::ST_OK;
    endcase
    rsp_nxt.cur_off  = top_nxt;
    rsp_nxt.prev_off = last_nxt;
  end

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        top_r  <= top_nxt;
        last_r <= last_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp_r <= rsp_nxt;
    end
  end

endmodule

@@ sv/arena_bump_allocator_core.sv @@
// A request accepted at the input is written into the request queue; the back end pops it
// and registers its result, which is then offered as the result beat.
// Throughput: one request per cycle while results are taken; the offset update is combinational.
// A two-beat request queue lets the input side run on while a result waits to be taken.
// Reset (synchronous, active low) clears both offsets, the queue, the output valid and
// the base address and arena length registers.
module arena_bump_allocator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [abump_pkg::ADDR_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [abump_pkg::FUNC_W-1:0]      in_func,
  input  logic [abump_pkg::OFF_W-1:0]       in_request_size,
  input  logic [abump_pkg::ALIGN_LOG_W-1:0] in_align_log2,
  input  logic [abump_pkg::ADDR_W-1:0]      in_old_address,
  input  logic [abump_pkg::OFF_W-1:0]       in_old_length,
  input  logic [abump_pkg::OFF_W-1:0]       in_snap_current,
  input  logic [abump_pkg::OFF_W-1:0]       in_snap_previous,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [abump_pkg::STATUS_W-1:0]    out_status,
  output logic [abump_pkg::ADDR_W-1:0]      out_result_address,
  output logic [abump_pkg::OFF_W-1:0]       out_copy_length,
  output logic [abump_pkg::OFF_W-1:0]       out_clear_offset,
  output logic [abump_pkg::OFF_W-1:0]       out_clear_length,
  output logic [abump_pkg::OFF_W-1:0]       out_current_offset,
  output logic [abump_pkg::OFF_W-1:0]       out_previous_offset
);

  localparam logic CFG_BASE   = 1'b0;
  localparam logic CFG_LENGTH = 1'b1;

  logic [abump_pkg::ADDR_W-1:0] base_address_r;
  logic [abump_pkg::OFF_W-1:0]  arena_length_r;
  logic [abump_pkg::OFF_W-1:0]  usable;

  abump_pkg::abump_req_t   front_req;
  abump_pkg::abump_req_t   back_req;
  abump_pkg::abump_rsp_t   rsp;
  abump_pkg::abump_qstat_t qstat;
  logic                    push;
  logic                    pop;

  assign cfg_ready = 1'b1;
  assign usable    = abump_pkg::usable_len(arena_length_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_address_r <= '0;
      arena_length_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BASE:   base_address_r <= cfg_data;
        CFG_LENGTH: arena_length_r <= cfg_data[abump_pkg::OFF_W-1:0];
        default:    base_address_r <= base_address_r;
      endcase
    end
  end

  abump_front u_front (
    .base_address     (base_address_r),
    .usable           (usable),
    .qstat            (qstat),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_request_size  (in_request_size),
    .in_align_log2    (in_align_log2),
    .in_old_address   (in_old_address),
    .in_old_length    (in_old_length),
    .in_snap_current  (in_snap_current),
    .in_snap_previous (in_snap_previous),
    .push             (push),
    .req              (front_req)
  );

  abump_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_req),
    .pop       (pop),
    .pop_data  (back_req),
    .qstat     (qstat)
  );

  abump_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .base_address (base_address_r),
    .usable       (usable),
    .qstat        (qstat),
    .req          (back_req),
    .pop          (pop),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .rsp          (rsp)
  );

  assign out_status          = rsp.status;
  assign out_result_address  = rsp.addr;
  assign out_copy_length     = rsp.copy_len;
  assign out_clear_offset    = rsp.clr_off;
  assign out_clear_length    = rsp.clr_len;
  assign out_current_offset  = rsp.cur_off;
  assign out_previous_offset = rsp.prev_off;

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.full |-> !in_ready)
    else $error("request queue full but input still ready");

  a_fail_no_address: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != abump_pkg::ST_OK) |->
      (out_result_address == '0 && out_copy_length == '0 && out_clear_length == '0))
    else $error("failed request reports a block or a region");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_result_address) &&
       $stable(out_copy_length) && $stable(out_clear_offset) &&
       $stable(out_clear_length) && $stable(out_current_offset) &&
       $stable(out_previous_offset)))
    else $error("result beat changed or dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("result valid or input blocked after reset");

endmodule

@@ tb/arena_bump_allocator_core_tb.sv @@
`timescale 1ns / 1ps

module arena_bump_allocator_core_tb;
  import abump_pkg::*;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_LEN  = 1'b1;

  localparam int unsigned STALL_LIMIT      = 4000;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned DRAIN_TAIL       = 4;
  localparam int unsigned MAX_REPORT_LINES = 100;
  localparam int          DIR_RESET_ROWS   = 6;
  localparam logic [ADDR_W-1:0] DIR_BASE   = 32'h0000_1000;
  localparam logic [ADDR_W-1:0] DIR_LEN    = 32'd256;

  typedef struct packed {
    logic [FUNC_W-1:0]      func;
    logic [OFF_W-1:0]       size;
    logic [ALIGN_LOG_W-1:0] align_log2;
    logic [ADDR_W-1:0]      old_addr;
    logic [OFF_W-1:0]       old_len;
    logic [OFF_W-1:0]       snap_cur;
    logic [OFF_W-1:0]       snap_prev;
  } arena_req_t;

  typedef struct packed {
    arena_req_t          req;
    logic                typed;
    logic [STATUS_W-1:0] want_status;
    logic [OFF_W-1:0]    want_cur;
    logic [OFF_W-1:0]    want_prev;
  } arena_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic                   cfg_index;
  logic [ADDR_W-1:0]      cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [FUNC_W-1:0]      in_func;
  logic [OFF_W-1:0]       in_request_size;
  logic [ALIGN_LOG_W-1:0] in_align_log2;
  logic [ADDR_W-1:0]      in_old_address;
  logic [OFF_W-1:0]       in_old_length;
  logic [OFF_W-1:0]       in_snap_current;
  logic [OFF_W-1:0]       in_snap_previous;
  logic                   out_valid;
  logic                   out_ready;
  logic [STATUS_W-1:0]    out_status;
  logic [ADDR_W-1:0]      out_result_address;
  logic [OFF_W-1:0]       out_copy_length;
  logic [OFF_W-1:0]       out_clear_offset;
  logic [OFF_W-1:0]       out_clear_length;
  logic [OFF_W-1:0]       out_current_offset;
  logic [OFF_W-1:0]       out_previous_offset;

  // Shadow of the allocator: configuration, both offsets and the last snapshot taken.
  logic [ADDR_W-1:0] arena_base = '0;
  logic [OFF_W-1:0]  arena_len  = '0;
  logic [OFF_W-1:0]  top_off    = '0;
  logic [OFF_W-1:0]  blk_off    = '0;
  logic [OFF_W-1:0]  kept_top   = '0;
  logic [OFF_W-1:0]  kept_blk   = '0;

  abump_rsp_t  predicted_rsp_q[$];
  arena_row_t  dir_rows[$];
  int unsigned mismatch_count = 0;
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_stall_pct   = 0;
  int unsigned rx_hold_req    = 0;

  arena_bump_allocator_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_request_size     (in_request_size),
    .in_align_log2       (in_align_log2),
    .in_old_address      (in_old_address),
    .in_old_length       (in_old_length),
    .in_snap_current     (in_snap_current),
    .in_snap_previous    (in_snap_previous),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_result_address  (out_result_address),
    .out_copy_length     (out_copy_length),
    .out_clear_offset    (out_clear_offset),
    .out_clear_length    (out_clear_length),
    .out_current_offset  (out_current_offset),
    .out_previous_offset (out_previous_offset)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned usable_bytes();
    return (arena_len < ARENA_MAX_BYTES) ? longint'(arena_len) : longint'(ARENA_MAX_BYTES);
  endfunction

  function automatic abump_rsp_t predict_alloc_response(input arena_req_t r);
    abump_rsp_t        rsp;
    longint unsigned   lim, sz, olen, oaddr, amask, ptr, off, top, copy;
    logic              zeroed, bump;
    rsp    = '0;
    lim    = usable_bytes();
    sz     = r.size;
    olen   = r.old_len;
    oaddr  = r.old_addr;
    amask  = (64'd1 << r.align_log2) - 64'd1;
    zeroed = (r.func == FN_ALLOC) || (r.func == FN_RESIZE);
    bump   = 1'b0;
    copy   = 0;
    case (r.func)
      FN_ALLOC, FN_ALLOC_NZ: bump = 1'b1;
      FN_FREE: rsp.status = ST_NO_FREE;
      FN_FREE_ALL: begin
        top_off = '0;
        blk_off = '0;
      end
      FN_RESIZE, FN_RESIZE_NZ: begin
        if (oaddr == 0 || olen == 0) begin
          // Nothing to carry over, so this is a plain allocation.
          bump = 1'b1;
        end else if (oaddr < arena_base || oaddr >= arena_base + lim) begin
          rsp.status = ST_BAD_OLD;
        end else if (oaddr == arena_base + blk_off && (oaddr & amask) == 0) begin
          // The last block changes size where it stands; the bound is checked first.
          top = blk_off + sz;
          if (top > lim) begin
            rsp.status = ST_NO_MEM;
          end else begin
            top_off  = OFF_W'(top);
            rsp.addr = ADDR_W'(oaddr);
            if (olen < sz && zeroed) begin
              rsp.clr_off = OFF_W'(blk_off + olen);
              rsp.clr_len = OFF_W'(sz - olen);
            end
          end
        end else begin
          bump = 1'b1;
          copy = (olen < sz) ? olen : sz;
        end
      end
      FN_SNAPSHOT: begin
        kept_top = top_off;
        kept_blk = blk_off;
      end
      FN_RESTORE: begin
        top_off = r.snap_cur;
        blk_off = r.snap_prev;
      end
    endcase
    if (bump) begin
      ptr = arena_base + top_off;
      off = ((ptr + amask) & ~amask) - arena_base;
      if (off + sz > lim) begin
        rsp.status = ST_NO_MEM;
      end else begin
        blk_off      = OFF_W'(off);
        top_off      = OFF_W'(off + sz);
        rsp.addr     = ADDR_W'(arena_base + off);
        rsp.copy_len = OFF_W'(copy);
        if (zeroed) begin
          rsp.clr_off = OFF_W'(off);
          rsp.clr_len = OFF_W'(sz);
        end
      end
    end
    rsp.cur_off  = top_off;
    rsp.prev_off = blk_off;
    return rsp;
  endfunction

  // Mostly well-formed traffic against the current shadow state, with some noise mixed in.
  function automatic arena_req_t gen_alloc_request();
    arena_req_t      r;
    longint unsigned lim;
    int unsigned     span, pick;
    lim  = usable_bytes();
    span = int'(lim / 8) + 4;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      r.size = OFF_W'($urandom);
    end else if (pick == 1) begin
      r.size = OFF_W'(lim);
    end else begin
      r.size = OFF_W'($urandom_range(0, span));
    end
    r.align_log2 = ($urandom_range(0, 9) == 0) ? ALIGN_LOG_W'($urandom)
                                               : ALIGN_LOG_W'($urandom_range(0, 5));
    r.old_addr  = $urandom;
    r.old_len   = OFF_W'($urandom);
    r.snap_cur  = OFF_W'($urandom);
    r.snap_prev = OFF_W'($urandom);
    pick = $urandom_range(0, 99);
    if (top_off * 4 > lim * 3 && $urandom_range(0, 3) == 0) begin
      pick = 80;
    end
    if (pick < 35) begin
      r.func = $urandom_range(0, 1) ? FN_ALLOC : FN_ALLOC_NZ;
    end else if (pick < 55) begin
      r.func     = $urandom_range(0, 1) ? FN_RESIZE : FN_RESIZE_NZ;
      r.old_addr = ADDR_W'(arena_base + blk_off);
      if (top_off > blk_off && $urandom_range(0, 3) != 0) begin
        r.old_len = top_off - blk_off;
      end else begin
        r.old_len = OFF_W'($urandom_range(1, span));
      end
    end else if (pick < 65) begin
      r.func     = $urandom_range(0, 1) ? FN_RESIZE : FN_RESIZE_NZ;
      r.old_addr = ADDR_W'(arena_base + $urandom_range(0, (lim > 0) ? 32'(lim - 1) : 0));
      r.old_len  = OFF_W'($urandom_range(1, span));
    end else if (pick < 70) begin
      r.func = $urandom_range(0, 1) ? FN_RESIZE : FN_RESIZE_NZ;
      if ($urandom_range(0, 1)) begin
        r.old_addr = '0;
      end else begin
        r.old_len = '0;
      end
    end else if (pick < 74) begin
      r.func = $urandom_range(0, 1) ? FN_RESIZE : FN_RESIZE_NZ;
      if ($urandom_range(0, 1)) begin
        r.old_addr = ADDR_W'(arena_base + lim);
      end
    end else if (pick < 78) begin
      r.func = FN_FREE;
    end else if (pick < 84) begin
      r.func = FN_FREE_ALL;
    end else if (pick < 90) begin
      r.func = FN_SNAPSHOT;
    end else begin
      r.func = FN_RESTORE;
      if (pick < 97) begin
        r.snap_cur  = kept_top;
        r.snap_prev = kept_blk;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORT_LINES) begin
      $display("ERROR %0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is 0x%0h, predicted 0x%0h", what, got, want));
    end
  endtask

  task automatic add_row(input logic [FUNC_W-1:0] func, input logic [OFF_W-1:0] size,
                         input logic [ALIGN_LOG_W-1:0] align_log2,
                         input logic [ADDR_W-1:0] old_addr, input logic [OFF_W-1:0] old_len,
                         input logic [OFF_W-1:0] snap_cur, input logic [OFF_W-1:0] snap_prev,
                         input logic typed = 1'b0,
                         input logic [STATUS_W-1:0] want_status = ST_OK,
                         input logic [OFF_W-1:0] want_cur = '0,
                         input logic [OFF_W-1:0] want_prev = '0);
    arena_row_t row;
    row.req.func       = func;
    row.req.size       = size;
    row.req.align_log2 = align_log2;
    row.req.old_addr   = old_addr;
    row.req.old_len    = old_len;
    row.req.snap_cur   = snap_cur;
    row.req.snap_prev  = snap_prev;
    row.typed          = typed;
    row.want_status    = want_status;
    row.want_cur       = want_cur;
    row.want_prev      = want_prev;
    dir_rows.push_back(row);
  endtask

  // Both registers go in as two beats with valid held high between them.
  task automatic write_config(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] len);
    cfg_valid <= 1'b1;
    cfg_index <= REG_BASE;
    cfg_data  <= base;
    do @(posedge clk); while (!cfg_ready);
    arena_base = base;
    cfg_index <= REG_LEN;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    arena_len = OFF_W'(len);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_request(input arena_req_t r);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= r.func;
    in_request_size  <= r.size;
    in_align_log2    <= r.align_log2;
    in_old_address   <= r.old_addr;
    in_old_length    <= r.old_len;
    in_snap_current  <= r.snap_cur;
    in_snap_previous <= r.snap_prev;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (predicted_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] len,
                           input int unsigned tx_pct, input int unsigned rx_pct,
                           input int unsigned count, input bit hold_off);
    arena_req_t r;
    write_config(base, len);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    if (hold_off) begin
      // The sink stops for a long stretch so the request queue backs up into in_ready.
      rx_hold_req = HOLD_CYCLES;
    end
    repeat (count) begin
      r = gen_alloc_request();
      send_request(r);
      predicted_rsp_q.push_back(predict_alloc_response(r));
      if ($urandom_range(0, 149) == 0) begin
        wait_drain();
      end
    end
    wait_drain();
  endtask

  initial begin : result_sink
    int unsigned hold;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != 0) begin
        hold        = rx_hold_req;
        rx_hold_req = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    abump_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_rsp_q.size() == 0) begin
        report_mismatch("result beat with no request outstanding");
      end else begin
        want = predicted_rsp_q.pop_front();
        check_field("status", 32'(out_status), 32'(want.status));
        check_field("result_address", out_result_address, want.addr);
        check_field("copy_length", 32'(out_copy_length), 32'(want.copy_len));
        check_field("clear_offset", 32'(out_clear_offset), 32'(want.clr_off));
        check_field("clear_length", 32'(out_clear_length), 32'(want.clr_len));
        check_field("current_offset", 32'(out_current_offset), 32'(want.cur_off));
        check_field("previous_offset", 32'(out_previous_offset), 32'(want.prev_off));
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("arena_bump_allocator_core: mismatch");
    $finish;
  end

  initial begin : stimulus
    abump_rsp_t rsp;
    int         i;
    rst_n            <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_index        <= REG_BASE;
    cfg_data         <= '0;
    in_valid         <= 1'b0;
    in_func          <= FN_ALLOC;
    in_request_size  <= '0;
    in_align_log2    <= '0;
    in_old_address   <= '0;
    in_old_length    <= '0;
    in_snap_current  <= '0;
    in_snap_previous <= '0;

    // Straight after reset, with an empty arena.
    add_row(FN_ALLOC,     0, 0, 0, 0, 0, 0, 1'b1, ST_OK,     0, 0);
    add_row(FN_ALLOC_NZ,  1, 0, 0, 0, 0, 0, 1'b1, ST_NO_MEM, 0, 0);
    add_row(FN_FREE,      0, 0, 0, 0, 0, 0, 1'b1, ST_NO_FREE, 0, 0);
    add_row(FN_SNAPSHOT,  0, 0, 0, 0, 0, 0, 1'b1, ST_OK,     0, 0);
    add_row(FN_RESTORE,   0, 0, 0, 0, 21'h1FFFFF, 21'h1FFFFF, 1'b1, ST_OK,
            21'h1FFFFF, 21'h1FFFFF);
    add_row(FN_FREE_ALL,  0, 0, 0, 0, 0, 0, 1'b1, ST_OK,     0, 0);
    // A 256-byte arena at 0x1000: growth and shrink in place, moves, bad old blocks.
    add_row(FN_ALLOC,     16, 4, 0, 0, 0, 0);
    add_row(FN_ALLOC_NZ,  5, 3, 0, 0, 0, 0);
    add_row(FN_RESIZE,    12, 3, 32'h1010, 5, 0, 0);
    add_row(FN_RESIZE_NZ, 4, 0, 32'h1010, 12, 0, 0);
    add_row(FN_RESIZE,    1000, 0, 32'h1010, 4, 0, 0);
    add_row(FN_RESIZE,    32, 5, 32'h1000, 16, 0, 0);
    add_row(FN_RESIZE_NZ, 8, 4, 32'h1010, 4, 0, 0);
    add_row(FN_RESIZE,    8, 0, 32'h0, 9, 0, 0);
    add_row(FN_RESIZE_NZ, 8, 3, 32'h1000, 0, 0, 0);
    add_row(FN_RESIZE,    8, 0, 32'h0FFF, 8, 0, 0);
    add_row(FN_RESIZE,    8, 0, 32'h1100, 8, 0, 0);
    add_row(FN_RESIZE_NZ, 4, 15, 32'h1050, 8, 0, 0);
    add_row(FN_ALLOC,     21'h1FFFFF, 0, 0, 0, 0, 0);
    add_row(FN_ALLOC_NZ,  0, 15, 0, 0, 0, 0);
    add_row(FN_SNAPSHOT,  0, 0, 0, 0, 0, 0);
    add_row(FN_RESTORE,   0, 0, 0, 0, 21'h0F0, 21'h0E0);
    add_row(FN_ALLOC,     16, 0, 0, 0, 0, 0);
    add_row(FN_ALLOC_NZ,  0, 0, 0, 0, 0, 0);
    add_row(FN_ALLOC,     1, 0, 0, 0, 0, 0);
    add_row(FN_FREE_ALL,  0, 0, 0, 0, 0, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    write_config('0, '0);
    for (i = 0; i < dir_rows.size(); i++) begin
      if (i == DIR_RESET_ROWS) begin
        wait_drain();
        write_config(DIR_BASE, DIR_LEN);
      end
      send_request(dir_rows[i].req);
      rsp = predict_alloc_response(dir_rows[i].req);
      if (dir_rows[i].typed) begin
        rsp          = '0;
        rsp.status   = dir_rows[i].want_status;
        rsp.cur_off  = dir_rows[i].want_cur;
        rsp.prev_off = dir_rows[i].want_prev;
      end
      predicted_rsp_q.push_back(rsp);
    end
    wait_drain();

    run_phase(32'hFFFF_FF00, 32'd1048576, 0, 0, 300, 1'b0);
    run_phase($urandom, 32'd4096, 88, 0, 250, 1'b0);
    run_phase('0, 32'h001F_FFFF, 0, 88, 250, 1'b0);
    run_phase($urandom & 32'hFFFF_F000, 32'd64, 17, 17, 300, 1'b0);
    run_phase($urandom, 32'd1024, 0, 0, 200, 1'b1);
    run_phase(32'hFFFF_FFFF, '0, 17, 17, 100, 1'b0);
    run_phase($urandom, $urandom_range(16, 65536), 0, 0, 150, 1'b0);

    if (mismatch_count == 0 && predicted_rsp_q.size() == 0) begin
      $display("arena_bump_allocator_core: match");
    end else begin
      $display("arena_bump_allocator_core: mismatch");
    end
    $finish;
  end

endmodule
